// ----- rtl/bdh_pkg.sv -----
// ----------------------------------------------------------------------------
// bdh_pkg
// Shared types and constants for the button debounce and hold detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdh_pkg;

  // Field widths of the ports
  localparam int BTN_FIELD_W   = 10;
  localparam int EVT_BTN_W     = 4;
  localparam int EVT_KIND_W    = 2;
  localparam int DEB_W         = 8;
  localparam int HOLD_W        = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;

  localparam int DEF_BUTTON_COUNT = 10;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_THRESHOLD     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LIMIT         = 2'd2;

  // Reset values of the configuration registers
  localparam logic [DEB_W-1:0]  RST_DEBOUNCE_THRESHOLD = 8'd5;
  localparam logic [HOLD_W-1:0] RST_HOLD_THRESHOLD     = 16'd200;
  localparam logic [HOLD_W-1:0] RST_HOLD_LIMIT         = 16'd200;

  // Event kind codes
  localparam logic [EVT_KIND_W-1:0] KIND_PRESS        = 2'd0;
  localparam logic [EVT_KIND_W-1:0] KIND_RELEASE      = 2'd1;
  localparam logic [EVT_KIND_W-1:0] KIND_HOLD_INSTANT = 2'd2;
  localparam logic [EVT_KIND_W-1:0] KIND_HOLD_CONT    = 2'd3;

  // Thresholds shared by every button
  typedef struct packed {
    logic [DEB_W-1:0]  debounce_threshold;
    logic [HOLD_W-1:0] hold_threshold;
    logic [HOLD_W-1:0] hold_limit;
  } cfg_t;

  // Per-button outcome of one tick
  typedef struct packed {
    logic clean;      // clean value after the tick
    logic press;
    logic release_ev;
    logic hold_inst;
    logic hold_cont;
  } btn_evt_t;

endpackage

// ----- rtl/bdh_button.sv -----
// ----------------------------------------------------------------------------
// bdh_button
// Debounce and hold counters of one button, updated once per accepted tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdh_button
  import bdh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,   // a tick request is accepted this cycle
  input  logic     raw,
  input  cfg_t     cfg,
  output btn_evt_t evt
);

  // The raw value taken when a button settles always equals the clean value,
  // so one bit serves as both.
  logic              clean;
  logic [DEB_W-1:0]  mismatch_count;
  logic [HOLD_W-1:0] hold_count;

  logic              clean_next;
  logic [DEB_W-1:0]  mismatch_count_next;
  logic [HOLD_W-1:0] hold_count_next;
  logic [DEB_W-1:0]  mc;
  logic              settle;

  // Tick evaluation
  always_comb begin
    mc         = (raw != clean) ? DEB_W'(mismatch_count + 1'b1) : mismatch_count;
    settle     = (mc >= cfg.debounce_threshold);
    clean_next = clean;
    mismatch_count_next = mc;
    hold_count_next     = hold_count;
    evt = '0;
    evt.hold_cont = clean;
    if (settle) begin
      clean_next          = raw;
      mismatch_count_next = '0;
      hold_count_next     = '0;
      evt.press           = raw;
      evt.release_ev      = ~raw;
    end else begin
      if (hold_count < cfg.hold_limit) begin
        hold_count_next = HOLD_W'(hold_count + 1'b1);
      end
      evt.hold_inst = clean && (hold_count_next >= cfg.hold_threshold);
    end
    evt.clean = clean_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clean          <= 1'b0;
      mismatch_count <= '0;
      hold_count     <= '0;
    end else if (advance) begin
      clean          <= clean_next;
      mismatch_count <= mismatch_count_next;
      hold_count     <= hold_count_next;
    end
  end

endmodule

// ----- rtl/button_debounce_hold_detector_unit.sv -----
// ----------------------------------------------------------------------------
// button_debounce_hold_detector_unit
// Debounces a vector of buttons and reports press, release and hold events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / raw_pressed): one request per scan
//   tick, bit i is button i, 1 = pressed.
//   Output channel (out_valid / out_stall / result fields): exactly one
//   result per tick, in order.
//   A tick accepted at an edge shows its result after that edge. One tick
//   per cycle is sustained while the receiver does not stall; each button's
//   next state is combinational and a result register sits on the output.
//   When the receiver stalls, the result holds and in_stall is raised;
//   a new tick is taken in the same cycle that the held result is taken.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
//   next edge; indexes beyond the register list are ignored.
//   Reset clears all button state and loads the default thresholds
//   (debounce 5, hold threshold 200, hold limit 200).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_hold_detector_unit
  import bdh_pkg::*;
#(
  parameter int BUTTON_COUNT = DEF_BUTTON_COUNT
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // tick input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BTN_FIELD_W-1:0] raw_pressed,
  // result output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [BTN_FIELD_W-1:0] clean_state,
  output logic [BTN_FIELD_W-1:0] press_events,
  output logic [BTN_FIELD_W-1:0] release_events,
  output logic [BTN_FIELD_W-1:0] hold_instant_events,
  output logic [BTN_FIELD_W-1:0] hold_continuous_events,
  output logic                   event_valid,
  output logic [EVT_BTN_W-1:0]   event_button,
  output logic [EVT_KIND_W-1:0]  event_kind
);

  localparam int VEC_W = (BUTTON_COUNT > BTN_FIELD_W) ? BUTTON_COUNT : BTN_FIELD_W;

  cfg_t     cfg;
  logic     accept;
  btn_evt_t evt [BUTTON_COUNT];

  logic [VEC_W-1:0]      clean_vec, press_vec, release_vec, hinst_vec, hcont_vec;
  logic                  ev_valid;
  logic [EVT_BTN_W-1:0]  ev_button;
  logic [EVT_KIND_W-1:0] ev_kind;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_threshold <= RST_DEBOUNCE_THRESHOLD;
      cfg.hold_threshold     <= RST_HOLD_THRESHOLD;
      cfg.hold_limit         <= RST_HOLD_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_THRESHOLD: cfg.debounce_threshold <= cfg_data[DEB_W-1:0];
        REG_HOLD_THRESHOLD:     cfg.hold_threshold     <= cfg_data[HOLD_W-1:0];
        REG_HOLD_LIMIT:         cfg.hold_limit         <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the output register frees up when its result is taken
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Per-button counters; buttons without an input bit see a released input
  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_btn
    logic raw_bit;
    if (g < BTN_FIELD_W) begin : g_in
      assign raw_bit = raw_pressed[g];
    end else begin : g_zero
      assign raw_bit = 1'b0;
    end
    bdh_button u_button (
      .clk     (clk),
      .rst     (rst),
      .advance (accept),
      .raw     (raw_bit),
      .cfg     (cfg),
      .evt     (evt[g])
    );
  end

  // Gather vectors and pick the highest-numbered button with an event
  always_comb begin
    clean_vec   = '0;
    press_vec   = '0;
    release_vec = '0;
    hinst_vec   = '0;
    hcont_vec   = '0;
    ev_valid    = 1'b0;
    ev_button   = '0;
    ev_kind     = '0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      clean_vec[i]   = evt[i].clean;
      press_vec[i]   = evt[i].press;
      release_vec[i] = evt[i].release_ev;
      hinst_vec[i]   = evt[i].hold_inst;
      hcont_vec[i]   = evt[i].hold_cont;
      if (evt[i].press || evt[i].release_ev || evt[i].hold_inst || evt[i].hold_cont) begin
        ev_valid  = 1'b1;
        ev_button = EVT_BTN_W'(i);
        if (evt[i].press) begin
          ev_kind = KIND_PRESS;
        end else if (evt[i].release_ev) begin
          ev_kind = KIND_RELEASE;
        end else if (evt[i].hold_inst) begin
          ev_kind = KIND_HOLD_INSTANT;
        end else begin
          ev_kind = KIND_HOLD_CONT;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      clean_state            <= clean_vec[BTN_FIELD_W-1:0];
      press_events           <= press_vec[BTN_FIELD_W-1:0];
      release_events         <= release_vec[BTN_FIELD_W-1:0];
      hold_instant_events    <= hinst_vec[BTN_FIELD_W-1:0];
      hold_continuous_events <= hcont_vec[BTN_FIELD_W-1:0];
      event_valid            <= ev_valid;
      event_button           <= ev_button;
      event_kind             <= ev_kind;
    end
  end

endmodule

// ----- rtl/bdh_checker.sv -----
// ----------------------------------------------------------------------------
// bdh_checker
// Port-level checks of the button debounce and hold detector results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdh_checker
  import bdh_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [BTN_FIELD_W-1:0] clean_state,
  input logic [BTN_FIELD_W-1:0] press_events,
  input logic [BTN_FIELD_W-1:0] release_events,
  input logic [BTN_FIELD_W-1:0] hold_instant_events,
  input logic [BTN_FIELD_W-1:0] hold_continuous_events,
  input logic                   event_valid,
  input logic [EVT_BTN_W-1:0]   event_button,
  input logic [EVT_KIND_W-1:0]  event_kind
);

  // A press lands in the clean state, a release clears it
  a_edge_matches_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((press_events & ~clean_state) == '0) &&
                  ((release_events & clean_state) == '0))
    else $error("press/release disagrees with clean_state");

  // Hold-instant only on a button that was already held and stays held
  a_hold_inst_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((hold_instant_events & ~hold_continuous_events) == '0) &&
                  ((hold_instant_events & ~clean_state) == '0))
    else $error("hold-instant on a button that was not held");

  // Summary flag follows the event vectors; no event gives zero fields
  a_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_valid == |(press_events | release_events |
                                   hold_instant_events | hold_continuous_events)) &&
                  (event_valid || (event_button == '0 && event_kind == '0)))
    else $error("event summary inconsistent with event vectors");

  // A stalled result holds its value
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(clean_state) &&
                               $stable(press_events) && $stable(event_kind))
    else $error("stalled result changed");

  // The input side is stalled only while a result waits
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

endmodule

bind button_debounce_hold_detector_unit bdh_checker u_bdh_checker (
  .clk                    (clk),
  .rst                    (rst),
  .in_valid               (in_valid),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .clean_state            (clean_state),
  .press_events           (press_events),
  .release_events         (release_events),
  .hold_instant_events    (hold_instant_events),
  .hold_continuous_events (hold_continuous_events),
  .event_valid            (event_valid),
  .event_button           (event_button),
  .event_kind             (event_kind)
);

// ----- sim/bdh_tick_scoreboard_pkg.sv -----
// ----------------------------------------------------------------------------
// bdh_tick_scoreboard_pkg
// Debounce and hold predictor plus an in-order queue of expected tick results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdh_tick_scoreboard_pkg;

  import bdh_pkg::*;

  // One result of the block, field for field
  typedef struct packed {
    logic [BTN_FIELD_W-1:0] clean_state;
    logic [BTN_FIELD_W-1:0] press;
    logic [BTN_FIELD_W-1:0] rel;
    logic [BTN_FIELD_W-1:0] hold_inst;
    logic [BTN_FIELD_W-1:0] hold_cont;
    logic                   ev_valid;
    logic [EVT_BTN_W-1:0]   ev_button;
    logic [EVT_KIND_W-1:0]  ev_kind;
  } tick_result_t;

  class tick_scoreboard;

    // thresholds as the block holds them
    logic [DEB_W-1:0]  deb_thr;
    logic [HOLD_W-1:0] hold_thr;
    logic [HOLD_W-1:0] hold_lim;

    // per-button state
    logic              acc_raw  [BTN_FIELD_W];
    logic              clean_v  [BTN_FIELD_W];
    logic [DEB_W-1:0]  mism_cnt [BTN_FIELD_W];
    logic [HOLD_W-1:0] hold_cnt [BTN_FIELD_W];

    tick_result_t expected_ticks [$];
    int           errors;

    function new();
      deb_thr  = RST_DEBOUNCE_THRESHOLD;
      hold_thr = RST_HOLD_THRESHOLD;
      hold_lim = RST_HOLD_LIMIT;
      for (int i = 0; i < BTN_FIELD_W; i++) begin
        acc_raw[i]  = 1'b0;
        clean_v[i]  = 1'b0;
        mism_cnt[i] = '0;
        hold_cnt[i] = '0;
      end
      errors = 0;
    endfunction

    // register write; unknown indexes are dropped
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEBOUNCE_THRESHOLD: deb_thr  = data[DEB_W-1:0];
        REG_HOLD_THRESHOLD:     hold_thr = data[HOLD_W-1:0];
        REG_HOLD_LIMIT:         hold_lim = data[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted scan tick: advance the state and queue its result
    function void note_request(logic [BTN_FIELD_W-1:0] raw);
      tick_result_t          res;
      logic [DEB_W-1:0]      mc;
      logic [EVT_KIND_W-1:0] kind;
      logic                  fired;
      res = '0;
      for (int i = 0; i < BTN_FIELD_W; i++) begin
        fired = 1'b0;
        kind  = KIND_PRESS;
        mc    = mism_cnt[i];
        // counter keeps growing, not cleared when the input returns to clean
        if (raw[i] != acc_raw[i]) mc = mc + 1'b1;
        if (clean_v[i]) begin
          res.hold_cont[i] = 1'b1;
          fired = 1'b1;
          kind  = KIND_HOLD_CONT;
        end
        if (mc < deb_thr) begin
          mism_cnt[i] = mc;
          if (hold_cnt[i] < hold_lim) hold_cnt[i] = hold_cnt[i] + 1'b1;
          if (hold_cnt[i] >= hold_thr && clean_v[i]) begin
            res.hold_inst[i] = 1'b1;
            fired = 1'b1;
            kind  = KIND_HOLD_INSTANT;
          end
        end else begin
          clean_v[i]  = raw[i];
          acc_raw[i]  = raw[i];
          mism_cnt[i] = '0;
          hold_cnt[i] = '0;
          fired = 1'b1;
          if (raw[i]) begin
            res.press[i] = 1'b1;
            kind = KIND_PRESS;
          end else begin
            res.rel[i] = 1'b1;
            kind = KIND_RELEASE;
          end
        end
        res.clean_state[i] = clean_v[i];
        // highest button with an event wins
        if (fired) begin
          res.ev_valid  = 1'b1;
          res.ev_button = EVT_BTN_W'(i);
          res.ev_kind   = kind;
        end
      end
      expected_ticks.push_back(res);
    endfunction

    function void cmp_field(string name, logic [BTN_FIELD_W-1:0] exp_v,
                            logic [BTN_FIELD_W-1:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
      end
    endfunction

    // one result taken from the block
    function void check_result(tick_result_t got);
      tick_result_t exp_r;
      if (expected_ticks.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none, got %h", $time, got);
        return;
      end
      exp_r = expected_ticks.pop_front();
      cmp_field("clean_state", exp_r.clean_state, got.clean_state);
      cmp_field("press_events", exp_r.press, got.press);
      cmp_field("release_events", exp_r.rel, got.rel);
      cmp_field("hold_instant_events", exp_r.hold_inst, got.hold_inst);
      cmp_field("hold_continuous_events", exp_r.hold_cont, got.hold_cont);
      cmp_field("event_valid", BTN_FIELD_W'(exp_r.ev_valid), BTN_FIELD_W'(got.ev_valid));
      cmp_field("event_button", BTN_FIELD_W'(exp_r.ev_button), BTN_FIELD_W'(got.ev_button));
      cmp_field("event_kind", BTN_FIELD_W'(exp_r.ev_kind), BTN_FIELD_W'(got.ev_kind));
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

  endclass

endpackage

// ----- sim/button_debounce_hold_detector_unit_tb.sv -----
// ----------------------------------------------------------------------------
// button_debounce_hold_detector_unit_tb
// Drives scan ticks through the debouncer under several threshold settings,
// with random gaps and stalls, and checks every result against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_hold_detector_unit_tb;

  import bdh_pkg::*;
  import bdh_tick_scoreboard_pkg::*;

  // index past the register list, written once to show it is ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [BTN_FIELD_W-1:0] raw_pressed;
  logic                   out_valid;
  logic                   out_stall;
  logic [BTN_FIELD_W-1:0] clean_state;
  logic [BTN_FIELD_W-1:0] press_events;
  logic [BTN_FIELD_W-1:0] release_events;
  logic [BTN_FIELD_W-1:0] hold_instant_events;
  logic [BTN_FIELD_W-1:0] hold_continuous_events;
  logic                   event_valid;
  logic [EVT_BTN_W-1:0]   event_button;
  logic [EVT_KIND_W-1:0]  event_kind;

  tick_scoreboard sb = new();
  bit quiet = 1'b0;   // no gaps and no stalls in the last part
  int results_seen = 0;

  always #6 clk = ~clk;

  button_debounce_hold_detector_unit i_dut (
    .clk                    (clk),
    .rst                    (rst),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .raw_pressed            (raw_pressed),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .clean_state            (clean_state),
    .press_events           (press_events),
    .release_events         (release_events),
    .hold_instant_events    (hold_instant_events),
    .hold_continuous_events (hold_continuous_events),
    .event_valid            (event_valid),
    .event_button           (event_button),
    .event_kind             (event_kind)
  );

  // wait for all results, then for the block to be idle
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // back-to-back register writes; upper debounce data bits are junk, dropped
  task automatic set_thresholds(input logic [DEB_W-1:0] deb, input logic [HOLD_W-1:0] hthr,
                                input logic [HOLD_W-1:0] hlim, input bit with_unused);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0]  dat [4];
    int n;
    idx[0] = REG_DEBOUNCE_THRESHOLD;
    dat[0] = {8'($urandom), deb};
    idx[1] = REG_HOLD_THRESHOLD;
    dat[1] = hthr;
    idx[2] = REG_HOLD_LIMIT;
    dat[2] = hlim;
    idx[3] = REG_UNUSED;
    dat[3] = 16'($urandom);
    n = with_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= dat[i];
      @(posedge clk);
      sb.write_reg(idx[i], dat[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // one scan tick request, with an optional gap ahead of it
  task automatic send_tick(input logic [BTN_FIELD_W-1:0] raw);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    raw_pressed <= raw;
    do @(posedge clk); while (in_stall);
    sb.note_request(raw);
  endtask

  // steady button patterns of random length, with glitches and some noise
  task automatic run_phase(input logic [DEB_W-1:0] deb, input logic [HOLD_W-1:0] hthr,
                           input logic [HOLD_W-1:0] hlim, input int n, input int max_seg);
    logic [BTN_FIELD_W-1:0] cur;
    logic [BTN_FIELD_W-1:0] val;
    int seg_left;
    wait_drained();
    set_thresholds(deb, hthr, hlim, 1'b0);
    cur = '0;
    seg_left = 0;
    for (int k = 0; k < n; k++) begin
      if (seg_left == 0) begin
        case ($urandom_range(0, 3))
          0: cur = '1;
          1: cur = '0;
          2: cur = BTN_FIELD_W'(1) << $urandom_range(0, BTN_FIELD_W - 1);
          default: cur = BTN_FIELD_W'($urandom);
        endcase
        seg_left = $urandom_range(1, max_seg);
      end
      seg_left--;
      val = cur;
      if ($urandom_range(0, 7) == 0) val[$urandom_range(0, BTN_FIELD_W - 1)] ^= 1'b1;
      if ($urandom_range(0, 19) == 0) val = BTN_FIELD_W'($urandom);
      send_tick(val);
    end
    in_valid <= 1'b0;
  endtask

  // result side: check, then pick the next stall
  initial begin
    int stall_left;
    bit held_off;
    tick_result_t got;
    stall_left = 0;
    held_off   = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = '{clean_state, press_events, release_events, hold_instant_events,
                hold_continuous_events, event_valid, event_button, event_kind};
        sb.check_result(got);
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!quiet && !held_off && results_seen >= 300) begin
        // long hold-off so the output register fills and in_stall rises
        held_off   = 1'b1;
        stall_left = 40;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      out_stall <= (stall_left > 0);
    end
  end

  // main sequence
  initial begin
    logic [BTN_FIELD_W-1:0] press_hold_seq [$];
    logic [BTN_FIELD_W-1:0] zero_thr_seq [$];
    press_hold_seq = '{10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF,
                       10'h000, 10'h3FF, 10'h000, 10'h155, 10'h155, 10'h2AA, 10'h2AA,
                       10'h001, 10'h200, 10'h000, 10'h3FF};
    zero_thr_seq   = '{10'h000, 10'h3FF, 10'h155, 10'h2AA, 10'h3FF, 10'h000};

    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    raw_pressed <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: press, hold past threshold with saturation, glitch that
    // does not clear the mismatch count, release, alternating buttons
    set_thresholds(8'd2, 16'd3, 16'd4, 1'b0);
    foreach (press_hold_seq[i]) send_tick(press_hold_seq[i]);
    in_valid <= 1'b0;

    // directed: zero debounce, zero hold threshold and zero hold limit
    wait_drained();
    set_thresholds(8'd0, 16'd0, 16'd0, 1'b1);
    foreach (zero_thr_seq[i]) send_tick(zero_thr_seq[i]);
    in_valid <= 1'b0;

    // random phases over several settings, extremes included
    run_phase(8'd5, 16'd200, 16'd200, 260, 260);
    run_phase(8'd1, 16'd10, 16'd12, 200, 30);
    run_phase(8'd255, 16'hFFFF, 16'hFFFF, 320, 300);
    run_phase(8'd3, 16'd0, 16'hFFFF, 180, 20);
    run_phase(8'd4, 16'd50, 16'd20, 150, 80);
    run_phase(DEB_W'($urandom_range(0, 8)), HOLD_W'($urandom_range(0, 40)),
              HOLD_W'($urandom_range(0, 60)), 200, 40);
    quiet = 1'b1;
    run_phase(8'd2, 16'd5, 16'd6, 120, 15);

    wait_drained();
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // timeout
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bdh_pkg.sv
rtl/bdh_button.sv
rtl/button_debounce_hold_detector_unit.sv
rtl/bdh_checker.sv
sim/bdh_tick_scoreboard_pkg.sv
sim/button_debounce_hold_detector_unit_tb.sv
